### hdl/skc_pkg.sv
`default_nettype none

package skc_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 64;

  localparam int IN_KEY_W = 64;
  localparam int POS_W    = 11;
  localparam int CNT_W    = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic                op;
    logic [IN_KEY_W-1:0] key;
  } skc_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] frequency;
    logic             status;
  } skc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture item, open search window
    logic probe_rd;    // read midpoint
    logic probe_cmp;   // narrow window on midpoint key
    logic check_rd;    // read lower bound entry
    logic finish;      // hit or no-change miss: update count, emit result
    logic shift_init;  // start moving entries up
    logic shift_step;  // one entry moved per cycle
    logic insert_new;  // write new key, emit result
  } skc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_more;
    logic hit;
    logic full;
    logic is_insert;
    logic shift_done;
  } skc_sts_t;

endpackage

`default_nettype wire

### hdl/skc_ctrl.sv
`default_nettype none

module skc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  skc_pkg::skc_sts_t sts,
  output skc_pkg::skc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PROBE_CMP,
    S_CHECK,
    S_SHIFT,
    S_WRITE_NEW
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.search_more) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_PROBE_CMP;
        end else begin
          cmd.check_rd = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_PROBE_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = S_PROBE;
      end
      S_CHECK: begin
        if (sts.hit || !sts.is_insert || sts.full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_WRITE_NEW;
        end
      end
      S_WRITE_NEW: begin
        cmd.insert_new = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### hdl/skc_dp.sv
`default_nettype none

module skc_dp #(
  parameter int CAPACITY = skc_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skc_pkg::KEY_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  skc_pkg::skc_in_t  in_item,
  input  skc_pkg::skc_cmd_t cmd,
  output skc_pkg::skc_sts_t sts,
  output logic              out_valid,
  output skc_pkg::skc_out_t out_item
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CNT_W = skc_pkg::CNT_W;
  localparam int POS_W = skc_pkg::POS_W;
  localparam int EW    = KEY_BITS + CNT_W;

  localparam logic [CW-1:0]    CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0]    ONE_C  = CW'(1);
  localparam logic [CNT_W-1:0] CNT1_C = CNT_W'(1);

  // entry = {key, count}
  logic [EW-1:0] mem [CAPACITY];

  logic [KEY_BITS-1:0] key_r;
  logic                op_r;
  logic [CW-1:0]       lo_r, hi_r, mid_r;
  logic [CW-1:0]       rd_ptr_r, wr_ptr_r;
  logic                pend_r;
  logic [CW-1:0]       entry_count_r;
  logic [EW-1:0]       rdata_r;
  logic                out_valid_r;
  skc_pkg::skc_out_t   out_r;

  logic [CW-1:0]       mid_nxt;
  logic [CW-1:0]       rd_dec;
  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0]    rd_cnt, cnt_inc;
  logic                hit, full, is_insert, shift_more;
  logic                rd_en;
  logic [CW-1:0]       rd_sel;
  logic                we;
  logic [CW-1:0]       wr_sel;
  logic [EW-1:0]       wd;
  logic [POS_W+CW-1:0] pos_ext;

  assign mid_nxt    = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_dec     = rd_ptr_r - ONE_C;
  assign rd_key     = rdata_r[EW-1:CNT_W];
  assign rd_cnt     = rdata_r[CNT_W-1:0];
  assign cnt_inc    = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT1_C;
  assign hit        = (lo_r < entry_count_r) && (rd_key == key_r);
  assign full       = (entry_count_r == CAP_C);
  assign is_insert  = (op_r == skc_pkg::OP_INSERT);
  assign shift_more = (rd_ptr_r > lo_r);
  assign pos_ext    = {{POS_W{1'b0}}, lo_r};

  assign sts.search_more = (lo_r < hi_r);
  assign sts.hit         = hit;
  assign sts.full        = full;
  assign sts.is_insert   = is_insert;
  assign sts.shift_done  = !shift_more && !pend_r;

  // read port select
  always_comb begin
    rd_en  = 1'b0;
    rd_sel = lo_r;
    if (cmd.probe_rd) begin
      rd_en  = 1'b1;
      rd_sel = mid_nxt;
    end else if (cmd.check_rd) begin
      rd_en  = 1'b1;
      rd_sel = lo_r;
    end else if (cmd.shift_step && shift_more) begin
      rd_en  = 1'b1;
      rd_sel = rd_dec;
    end
  end

  // write port select; a pending shift write only occurs in the shift phase
  always_comb begin
    we     = 1'b0;
    wr_sel = lo_r;
    wd     = {key_r, CNT1_C};
    if (pend_r) begin
      we     = 1'b1;
      wr_sel = wr_ptr_r;
      wd     = rdata_r;
    end else if (cmd.finish && hit && is_insert) begin
      we = 1'b1;
      wd = {rd_key, cnt_inc};
    end else if (cmd.insert_new) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_sel[AW-1:0]];
    end
    if (we) begin
      mem[wr_sel[AW-1:0]] <= wd;
    end
  end

  // search window and shift pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_item.key[KEY_BITS-1:0];
      op_r  <= in_item.op;
      lo_r  <= '0;
      hi_r  <= entry_count_r;
    end
    if (cmd.probe_rd) begin
      mid_r <= mid_nxt;
    end
    if (cmd.probe_cmp) begin
      if (rd_key < key_r) begin
        lo_r <= mid_r + ONE_C;
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.shift_init) begin
      rd_ptr_r <= entry_count_r;
    end else if (cmd.shift_step && shift_more) begin
      rd_ptr_r <= rd_dec;
      wr_ptr_r <= rd_ptr_r;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.found    <= hit;
      out_r.position <= pos_ext[POS_W-1:0];
      out_r.status   <= (!hit && is_insert && full) ? skc_pkg::ST_FULL : skc_pkg::ST_OK;
      if (hit) begin
        out_r.frequency <= is_insert ? cnt_inc : rd_cnt;
      end else begin
        out_r.frequency <= '0;
      end
    end else if (cmd.insert_new) begin
      out_r.found     <= 1'b0;
      out_r.position  <= pos_ext[POS_W-1:0];
      out_r.frequency <= CNT1_C;
      out_r.status    <= skc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      pend_r      <= cmd.shift_step && shift_more;
      out_valid_r <= cmd.finish || cmd.insert_new;
      if (cmd.insert_new) begin
        entry_count_r <= entry_count_r + ONE_C;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### hdl/sorted_key_table_counter.sv
// Flow: load, then binary-search probes (a midpoint read, then a compare), at most
//   ceil(log2(entries+1)) of them, 11 at CAPACITY 1024, then a lower-bound check read.
// A new key then moves the entries above it up one place and is written with count 1.
// Throughput: one item at a time, busy until it is finished; the pace is set by the
//   single read port of the entry RAM (one entry moved a cycle).
// Reset: entry count cleared, RAM not cleared; out_valid cannot be stalled by the receiver.
`default_nettype none

module sorted_key_table_counter #(
  parameter int CAPACITY = skc_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skc_pkg::KEY_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  // input channel: transfer when start is high and busy is low
  input  wire               start,
  output logic              busy,
  input  skc_pkg::skc_in_t  in_item,
  // result channel: one-cycle strobe, no back-pressure
  output logic              out_valid,
  output skc_pkg::skc_out_t out_item
);

  // command and status between the sequencer and the datapath
  skc_pkg::skc_cmd_t cmd;
  skc_pkg::skc_sts_t sts;

  // Sequencer: load, binary-search probes (read then compare), lower-bound check,
  // then either finish at once (hit, search-only miss, full table) or shift entries
  // above the insertion point up one place and write the new key with count 1.
  skc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: entry RAM {key, count}, search window lo/hi, shift pointers,
  // entry count and the registered result.
  skc_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### tb/sv/tb_sorted_key_table_counter.sv
`default_nettype none

module tb_sorted_key_table_counter;
  import skc_pkg::*;

  localparam int CAP   = CAPACITY_DEF;
  localparam int KBITS = KEY_BITS_DEF;

  localparam logic [IN_KEY_W-1:0] KEY_MASK  = {IN_KEY_W{1'b1}} >> (IN_KEY_W - KBITS);
  localparam logic [IN_KEY_W-1:0] KEY_TOP   = {IN_KEY_W{1'b1}};
  // fill keys sit just under the all-ones key, so appends barely shift anything
  localparam logic [IN_KEY_W-1:0] FILL_BASE = 64'hFFFF_FFFF_FFFF_F800;
  localparam logic [CNT_W-1:0]    CNT_MAX   = {CNT_W{1'b1}};

  // watchdog for a hung run; the worst case is roughly 1500 items plus gaps
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int     MAX_REPORTS = 10;
  localparam int     RAND_ITEMS  = 470;
  localparam int     FULL_ITEMS  = 100;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  skc_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  skc_out_t out_item;

  // one directed row; res is only meaningful when typed is set
  typedef struct {
    logic                op;
    logic [IN_KEY_W-1:0] key;
    bit                  typed;
    skc_out_t            res;
  } dir_row_t;

  // shadow copy of the table, kept in ascending key order
  logic [IN_KEY_W-1:0] tab_key [CAP];
  logic [CNT_W-1:0]    tab_cnt [CAP];
  int unsigned         tab_len = 0;

  skc_out_t pending_results[$];
  skc_out_t next_res;
  int       mismatches = 0;
  int       strays     = 0;
  longint   cycles     = 0;
  int       burst_left = 0;
  bit       start_q    = 1'b0;  // what start was last scheduled to be

  sorted_key_table_counter #(
    .CAPACITY (CAP),
    .KEY_BITS (KBITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Predictor: lower-bound binary search, then count, insert with shift, or reject.
  task automatic count_key(input skc_in_t it, output skc_out_t res);
    logic [IN_KEY_W-1:0] k;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         mid;
    bit                  hit;
    k  = it.key & KEY_MASK;
    lo = 0;
    hi = tab_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tab_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < tab_len) && (tab_key[lo] == k);
    res.found     = hit;
    res.position  = lo[POS_W-1:0];
    res.frequency = '0;
    res.status    = ST_OK;
    if (hit) begin
      // count saturates at all ones
      if (it.op == OP_INSERT && tab_cnt[lo] != CNT_MAX) tab_cnt[lo] = tab_cnt[lo] + 1'b1;
      res.frequency = tab_cnt[lo];
    end else if (it.op == OP_INSERT) begin
      if (tab_len >= CAP) begin
        res.status = ST_FULL;   // full table: state untouched
      end else begin
        for (int i = tab_len; i > lo; i--) begin
          tab_key[i] = tab_key[i-1];
          tab_cnt[i] = tab_cnt[i-1];
        end
        tab_key[lo]   = k;
        tab_cnt[lo]   = 1;
        tab_len       = tab_len + 1;
        res.frequency = 1;
      end
    end
  endtask

  function automatic dir_row_t mk_row(logic op, logic [IN_KEY_W-1:0] key, bit typed,
                                      logic found, int pos, int freq, logic st);
    dir_row_t r;
    r.op               = op;
    r.key              = key;
    r.typed            = typed;
    r.res.found        = found;
    r.res.position     = pos[POS_W-1:0];
    r.res.frequency    = freq[CNT_W-1:0];
    r.res.status       = st;
    return r;
  endfunction

  // Random key mix: keys already held (hits), their neighbors, small values,
  // short text words, and fully random words.
  function automatic logic [IN_KEY_W-1:0] pick_key();
    int                  sel;
    int                  len;
    logic [IN_KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k   = '0;
    if (sel < 35 && tab_len > 0) begin
      k = tab_key[$urandom_range(0, tab_len - 1)];
    end else if (sel < 45 && tab_len > 0) begin
      k = tab_key[$urandom_range(0, tab_len - 1)];
      k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
    end else if (sel < 55) begin
      k = $urandom_range(0, 15);
    end else if (sel < 65) begin
      // big-endian text, zero padded
      len = $urandom_range(1, 8);
      for (int b = 0; b < 8; b++)
        if (b < len) k[63 - 8*b -: 8] = 8'h61 + $urandom_range(0, 25);
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  function automatic skc_in_t rand_item();
    skc_in_t it;
    it.key = pick_key();
    it.op  = ($urandom_range(0, 3) == 0) ? OP_SEARCH : OP_INSERT;
    // the all-ones key never enters the table, so an insertion point past the
    // last slot can be shown once the table is full
    if (it.key == KEY_TOP) it.op = OP_SEARCH;
    return it;
  endfunction

  // Present one item and hold it until the transfer (start high, busy low at an edge).
  task automatic send_item(input skc_in_t it, input bit typed, input skc_out_t typed_res);
    skc_out_t res;
    start   <= 1'b1;
    start_q  = 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    count_key(it, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Sender idles: start low, junk on the item bus so only start qualifies it.
  task automatic idle_gap(input int n);
    skc_in_t junk;
    junk.op  = $urandom_range(0, 1);
    junk.key = {$urandom, $urandom};
    if (start_q) begin
      start   <= 1'b0;
      start_q  = 1'b0;
    end
    in_item <= junk;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of back-to-back transfers separated by gaps; some bursts are long.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 40));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    if (start_q) begin
      start   <= 1'b0;
      start_q  = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: every strobe is compared with the oldest prediction.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_key_table_counter verification failed");
      $finish;
    end else if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        if (mismatches + strays < MAX_REPORTS)
          $display("cycle %0d: unexpected result found=%0b pos=%0d freq=%0d status=%0b",
                   cycles, out_item.found, out_item.position, out_item.frequency,
                   out_item.status);
        strays++;
      end else begin
        next_res = pending_results.pop_front();
        if (out_item.found !== next_res.found || out_item.position !== next_res.position ||
            out_item.frequency !== next_res.frequency || out_item.status !== next_res.status) begin
          if (mismatches + strays < MAX_REPORTS)
            $display("cycle %0d: mismatch exp found=%0b pos=%0d freq=%0d status=%0b got found=%0b pos=%0d freq=%0d status=%0b",
                     cycles, next_res.found, next_res.position, next_res.frequency,
                     next_res.status, out_item.found, out_item.position,
                     out_item.frequency, out_item.status);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table, random mix, fill to capacity, then traffic on a full table.
  initial begin
    dir_row_t rows[$];
    skc_in_t  it;
    skc_out_t none;
    int       j;

    none = '0;
    // empty table, typed-in results
    rows.push_back(mk_row(OP_SEARCH, 64'h0,                  1, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h0,                  1, 1'b0, 0, 1, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h0,                  1, 1'b1, 0, 2, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, KEY_TOP,                1, 1'b0, 1, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b0, 1, 1, ST_OK));
    // lands between: shifts the near-max key up
    rows.push_back(mk_row(OP_INSERT, 64'h8000_0000_0000_0000, 1, 1'b0, 1, 1, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1'b0, 1, 0, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b1, 2, 1, ST_OK));
    // text keys and mixed traffic, predictor checked
    rows.push_back(mk_row(OP_INSERT, 64'h6869_0000_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h6869_7400_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h6100_0000_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h6869_0000_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, 64'h6869_7400_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h1,                  0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, 64'h2,                  0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h5555_5555_5555_5555, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h0,                  0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, KEY_TOP,                0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFD, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_SEARCH, 64'h8000_0000_0000_0000, 0, 1'b0, 0, 0, ST_OK));
    rows.push_back(mk_row(OP_INSERT, 64'h1,                  0, 1'b0, 0, 0, ST_OK));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      it.op  = rows[i].op;
      it.key = rows[i].key;
      send_item(it, rows[i].typed, rows[i].res);
      pace();
    end
    // hold off until the block is fully quiet before random traffic
    drain();

    repeat (RAND_ITEMS) begin
      send_item(rand_item(), 1'b0, none);
      pace();
    end
    drain();

    // fill to capacity back to back; keys near the top append without long shifts
    j = 0;
    while (tab_len < CAP) begin
      it.op  = OP_INSERT;
      it.key = FILL_BASE + j;
      j++;
      send_item(it, 1'b0, none);
    end

    // full table: insertion point past the last slot, then a rejected insert
    it.op  = OP_SEARCH;
    it.key = KEY_TOP;
    send_item(it, 1'b0, none);
    it.op  = OP_INSERT;
    send_item(it, 1'b0, none);
    pace();
    repeat (FULL_ITEMS) begin
      send_item(rand_item(), 1'b0, none);
      pace();
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && strays == 0 && pending_results.size() == 0) begin
      $display("sorted_key_table_counter verification clean");
    end else begin
      $display("sorted_key_table_counter verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
